// ===== sv/fha_pkg.sv =====
`default_nettype none
package fha_pkg;

	localparam int HDR_BYTES      = 8;
	localparam int SPLIT_MIN      = 32;
	localparam int MIN_HEAP_BYTES = 4096;
	localparam int STATUS_W       = 2;
	localparam int OFFSET_W       = 14;
	localparam int COUNT_W        = 12;
	localparam int SIZE_IN_W      = 15;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_FIT   = 2'd1,
		ST_BAD_FREE = 2'd2,
		ST_BAD_SIZE = 2'd3
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_AWALK,
		S_FWALK,
		S_FRIGHT,
		S_FWRITE,
		S_WR2,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== sv/fha_if.sv =====
`default_nettype none
interface fha_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [14:0] request_size;
	logic [13:0] data_offset;
	modport source (output valid, operation, request_size, data_offset, input ready);
	modport sink (input valid, operation, request_size, data_offset, output ready);
endinterface

interface fha_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [13:0] result_offset;
	logic [11:0] free_chunks;
	modport source (output valid, status, result_offset, free_chunks, input ready);
	modport sink (input valid, status, result_offset, free_chunks, output ready);
endinterface

interface fha_cfg_if;
	logic        valid;
	logic        ready;
	logic [14:0] size_bytes;
	modport source (output valid, size_bytes, input ready);
	modport sink (input valid, size_bytes, output ready);
endinterface
`default_nettype wire

// ===== sv/fha_mem.sv =====
`default_nettype none
module fha_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/first_fit_heap_allocator.sv =====
// First-fit heap allocator over a heap of 4-byte words with 8-byte chunk headers.
// Channels: req takes one beat per operation (allocate or free), rsp gives one
// beat per operation with status, data offset and free chunk count, cfg writes
// the heap size in bytes and reinitialises the heap to one free chunk.
// Chunk headers live in a single-port-read, single-port-write RAM with a registered
// read; one header is read per cycle while walking the chunk list. One operation is
// in flight at a time; the header read port sets the walk rate.
// A cfg beat is taken only while idle and then rewrites header 0 in the init state.
// After reset the heap is 4096 bytes, one free chunk; the init state after
// reset rewrites header 0 and no request is taken in that state.
// The result sits in an output register: a new request is taken while it waits,
// and that request's result holds in the engine until rsp is free.
`default_nettype none
module first_fit_heap_allocator
	import fha_pkg::*;
#(
	parameter int HEAP_CAPACITY = 16384
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fha_req_if.sink    req,
	fha_rsp_if.source  rsp,
	fha_cfg_if.sink    cfg
);

	localparam int WORDS = HEAP_CAPACITY / 4;
	localparam int AW    = $clog2(WORDS);
	localparam int PW    = $clog2(HEAP_CAPACITY) + 1;
	localparam int CW    = (PW > 16) ? PW : 16;
	localparam int NW    = CW + 1;
	localparam int DW    = PW + 1;
	localparam int FW    = PW;
	localparam logic [CW-1:0] CAP_BYTES = CW'((HEAP_CAPACITY / 4) * 4);
	localparam logic [CW-1:0] MIN_BYTES = CW'(MIN_HEAP_BYTES);
	localparam logic [CW-1:0] HDR_C     = CW'(HDR_BYTES);

	state_t state_q, state_d;

	logic [CW-1:0] heap_q, heap_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [CW-1:0] target_q, target_d;
	logic [NW-1:0] need_q, need_d;
	logic [CW-1:0] prev_pos_q, prev_pos_d;
	logic [CW-1:0] prev_size_q, prev_size_d;
	logic          prev_free_q, prev_free_d;
	logic          has_prev_q, has_prev_d;
	logic [CW-1:0] hsize_q, hsize_d;
	logic [FW-1:0] fc_q, fc_d;
	status_t       status_q, status_d;
	logic [CW-1:0] offset_q, offset_d;
	logic [AW-1:0] wr2_addr_q, wr2_addr_d;
	logic [DW-1:0] wr2_data_q, wr2_data_d;

	logic          out_valid_q;
	status_t       out_status_q;
	logic [OFFSET_W-1:0] out_offset_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic          out_load;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [DW-1:0] mem_wdata, mem_rdata;

	logic          r_free;
	logic [CW-1:0] r_size;
	logic [CW-1:0] next_pos;
	logic [CW-1:0] split_pos;
	logic [CW:0]   cfg_rnd;
	logic [CW-1:0] cfg_bytes;

	fha_mem #(
		.DEPTH(WORDS),
		.AW   (AW),
		.DW   (DW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign r_free    = mem_rdata[PW];
	assign r_size    = CW'(mem_rdata[PW-1:0]);
	assign next_pos  = pos_q + r_size;
	assign split_pos = pos_q + CW'(need_q);

	// round up to a word and clamp into the legal heap range
	always_comb begin
		cfg_rnd = ((CW+1)'(cfg.size_bytes) + (CW+1)'(3)) & ~(CW+1)'(3);
		if (cfg_rnd < (CW+1)'(MIN_BYTES)) begin
			cfg_bytes = MIN_BYTES;
		end else if (cfg_rnd > (CW+1)'(CAP_BYTES)) begin
			cfg_bytes = CAP_BYTES;
		end else begin
			cfg_bytes = cfg_rnd[CW-1:0];
		end
	end

	assign cfg.ready = (state_q == S_IDLE);
	assign req.ready = (state_q == S_IDLE) && !cfg.valid;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			heap_q  <= MIN_BYTES;
			fc_q    <= FW'(1);
		end else begin
			state_q <= state_d;
			heap_q  <= heap_d;
			fc_q    <= fc_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q       <= pos_d;
		target_q    <= target_d;
		need_q      <= need_d;
		prev_pos_q  <= prev_pos_d;
		prev_size_q <= prev_size_d;
		prev_free_q <= prev_free_d;
		has_prev_q  <= has_prev_d;
		hsize_q     <= hsize_d;
		status_q    <= status_d;
		offset_q    <= offset_d;
		wr2_addr_q  <= wr2_addr_d;
		wr2_data_q  <= wr2_data_d;
	end

	always_comb begin
		state_d     = state_q;
		heap_d      = heap_q;
		fc_d        = fc_q;
		pos_d       = pos_q;
		target_d    = target_q;
		need_d      = need_q;
		prev_pos_d  = prev_pos_q;
		prev_size_d = prev_size_q;
		prev_free_d = prev_free_q;
		has_prev_d  = has_prev_q;
		hsize_d     = hsize_q;
		status_d    = status_q;
		offset_d    = offset_q;
		wr2_addr_d  = wr2_addr_q;
		wr2_data_d  = wr2_data_q;
		mem_we      = 1'b0;
		mem_waddr   = pos_q[AW+1:2];
		mem_wdata   = {1'b1, PW'(heap_q)};
		mem_re      = 1'b0;
		mem_raddr   = next_pos[AW+1:2];

		case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = {1'b1, PW'(heap_q)};
				fc_d      = FW'(1);
				state_d   = S_IDLE;
			end
			S_IDLE: begin
				if (cfg.valid) begin
					heap_d  = cfg_bytes;
					state_d = S_INIT;
				end else if (req.valid) begin
					pos_d      = '0;
					offset_d   = '0;
					has_prev_d = 1'b0;
					status_d   = ST_OK;
					need_d     = (((NW'(req.request_size) + NW'(3)) & ~NW'(3))
						+ NW'(HDR_BYTES));
					target_d   = CW'(req.data_offset) - HDR_C;
					if (req.operation == OP_ALLOC) begin
						if (req.request_size == '0) begin
							status_d = ST_BAD_SIZE;
							state_d  = S_DONE;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = '0;
							state_d   = S_AWALK;
						end
					end else begin
						if (CW'(req.data_offset) < HDR_C) begin
							status_d = ST_BAD_FREE;
							state_d  = S_DONE;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = '0;
							state_d   = S_FWALK;
						end
					end
				end
			end
			S_AWALK: begin
				if (r_size < HDR_C) begin
					status_d = ST_NO_FIT;
					state_d  = S_DONE;
				end else if (r_free && (NW'(r_size) >= need_q)) begin
					mem_we   = 1'b1;
					offset_d = pos_q + HDR_C;
					if (NW'(r_size) >= need_q + NW'(SPLIT_MIN)) begin
						mem_wdata  = {1'b0, PW'(need_q)};
						wr2_addr_d = split_pos[AW+1:2];
						wr2_data_d = {1'b1, PW'(r_size - CW'(need_q))};
						state_d    = S_WR2;
					end else begin
						mem_wdata = {1'b0, PW'(r_size)};
						if (fc_q != '0) begin
							fc_d = fc_q - FW'(1);
						end
						state_d = S_DONE;
					end
				end else begin
					pos_d = next_pos;
					if (next_pos >= heap_q) begin
						status_d = ST_NO_FIT;
						state_d  = S_DONE;
					end else begin
						mem_re = 1'b1;
					end
				end
			end
			S_FWALK: begin
				if (pos_q == target_q) begin
					if (r_free) begin
						status_d = ST_BAD_FREE;
						state_d  = S_DONE;
					end else begin
						hsize_d = r_size;
						fc_d    = fc_q + FW'(1);
						if (next_pos < heap_q) begin
							mem_re  = 1'b1;
							state_d = S_FRIGHT;
						end else begin
							state_d = S_FWRITE;
						end
					end
				end else if (r_size < HDR_C) begin
					status_d = ST_BAD_FREE;
					state_d  = S_DONE;
				end else begin
					prev_pos_d  = pos_q;
					prev_size_d = r_size;
					prev_free_d = r_free;
					has_prev_d  = 1'b1;
					pos_d       = next_pos;
					if (next_pos >= heap_q) begin
						status_d = ST_BAD_FREE;
						state_d  = S_DONE;
					end else begin
						mem_re = 1'b1;
					end
				end
			end
			S_FRIGHT: begin
				if (r_free) begin
					hsize_d = hsize_q + r_size;
					fc_d    = fc_q - FW'(1);
				end
				state_d = S_FWRITE;
			end
			S_FWRITE: begin
				mem_we    = 1'b1;
				mem_waddr = target_q[AW+1:2];
				mem_wdata = {1'b1, PW'(hsize_q)};
				if (has_prev_q && prev_free_q) begin
					wr2_addr_d = prev_pos_q[AW+1:2];
					wr2_data_d = {1'b1, PW'(prev_size_q + hsize_q)};
					fc_d       = fc_q - FW'(1);
					state_d    = S_WR2;
				end else begin
					state_d = S_DONE;
				end
			end
			S_WR2: begin
				mem_we    = 1'b1;
				mem_waddr = wr2_addr_q;
				mem_wdata = wr2_data_q;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_offset_q <= (status_q == ST_OK) ? OFFSET_W'(offset_q) : '0;
			out_count_q  <= COUNT_W'(fc_q);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.result_offset = out_offset_q;
	assign rsp.free_chunks   = out_count_q;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_re |-> mem_waddr != mem_raddr)
		else $error("header read and write hit the same word");

	a_offset_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_OK |-> out_offset_q == '0)
		else $error("offset given on a failed operation");

	a_cfg_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready |=> state_q == S_INIT)
		else $error("heap size beat did not reinitialise");

	a_heap_range: assert property (@(posedge clk) disable iff (!arst_n)
		heap_q >= MIN_BYTES && heap_q <= CAP_BYTES)
		else $error("heap size out of range");

endmodule
`default_nettype wire

// ===== test/tb_first_fit_heap_allocator.sv =====
`default_nettype none
module tb_first_fit_heap_allocator;
	import fha_pkg::*;

	localparam int CAP   = 16384;
	localparam int WORDS = CAP / 4;

	typedef struct packed {
		status_t     status;
		logic [13:0] result_offset;
		logic [11:0] free_chunks;
	} alloc_reply_t;

	class reply_board;
		alloc_reply_t pending[$];
		int fails;
		function void note_request(alloc_reply_t r);
			pending.push_back(r);
		endfunction
		function void check_reply(alloc_reply_t got);
			alloc_reply_t want;
			if (pending.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected beat status=%0d off=%0d free=%0d",
						got.status, got.result_offset, got.free_chunks);
				return;
			end
			want = pending.pop_front();
			if (want !== got) begin
				fails++;
				if (fails <= 10)
					$display("mismatch exp st=%0d off=%0d free=%0d got st=%0d off=%0d free=%0d",
						want.status, want.result_offset, want.free_chunks,
						got.status, got.result_offset, got.free_chunks);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	fha_req_if req();
	fha_rsp_if rsp();
	fha_cfg_if cfg();

	first_fit_heap_allocator dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	initial begin
		forever #2 clk = ~clk;
	end

	// heap model
	logic        hfree[WORDS];
	int unsigned hsize[WORDS];
	int unsigned heap_bytes;
	int unsigned nfree;
	int unsigned live[$];
	reply_board board;

	function automatic void heap_init(int unsigned v);
		int unsigned b;
		b = (v + 3) & ~32'd3;
		if (b < MIN_HEAP_BYTES) b = MIN_HEAP_BYTES;
		if (b > CAP) b = CAP;
		heap_bytes = b;
		for (int i = 0; i < WORDS; i++) begin
			hfree[i] = 0;
			hsize[i] = 0;
		end
		hfree[0] = 1;
		hsize[0] = b;
		nfree = 1;
		live.delete();
	endfunction

	function automatic alloc_reply_t predict_alloc(int unsigned req_sz);
		alloc_reply_t r;
		int unsigned need, pos, sz;
		r.status = ST_NO_FIT;
		r.result_offset = 0;
		pos = 0;
		if (req_sz == 0) r.status = ST_BAD_SIZE;
		else begin
			need = ((req_sz + 3) & ~32'd3) + HDR_BYTES;
			while (pos < heap_bytes) begin
				sz = hsize[pos >> 2];
				if (sz < HDR_BYTES) break;
				if (hfree[pos >> 2] && sz >= need) begin
					if (sz >= need + SPLIT_MIN) begin
						hfree[pos >> 2] = 0;
						hsize[pos >> 2] = need;
						hfree[(pos + need) >> 2] = 1;
						hsize[(pos + need) >> 2] = sz - need;
					end else begin
						hfree[pos >> 2] = 0;
						if (nfree > 0) nfree--;
					end
					r.status = ST_OK;
					r.result_offset = 14'(pos + HDR_BYTES);
					live.push_back(pos + HDR_BYTES);
					break;
				end
				pos += sz;
			end
		end
		r.free_chunks = 12'(nfree);
		return r;
	endfunction

	function automatic alloc_reply_t predict_free(int unsigned off);
		alloc_reply_t r;
		int unsigned tgt, pos, prv, sz;
		bit has_prv, found;
		r.status = ST_BAD_FREE;
		r.result_offset = 0;
		pos = 0; prv = 0; has_prv = 0; found = 0;
		if (off >= HDR_BYTES) begin
			tgt = off - HDR_BYTES;
			while (pos < heap_bytes) begin
				if (pos == tgt) begin
					found = 1;
					break;
				end
				if (hsize[pos >> 2] < HDR_BYTES) break;
				prv = pos;
				has_prv = 1;
				pos += hsize[pos >> 2];
			end
			if (found && !hfree[tgt >> 2] && hsize[tgt >> 2] != 0) begin
				r.status = ST_OK;
				sz = hsize[tgt >> 2];
				nfree++;
				if (tgt + sz < heap_bytes && hfree[(tgt + sz) >> 2]) begin
					sz += hsize[(tgt + sz) >> 2];
					nfree--;
				end
				hfree[tgt >> 2] = 1;
				hsize[tgt >> 2] = sz;
				if (has_prv && hfree[prv >> 2]) begin
					hsize[prv >> 2] = hsize[prv >> 2] + sz;
					nfree--;
				end
				foreach (live[i]) if (live[i] == off) begin
					live.delete(i);
					break;
				end
			end
		end
		r.free_chunks = 12'(nfree);
		return r;
	endfunction

	// the model treats an all-zero header as neither alloc nor free; a free needs a
	// nonzero size as well as a clear free flag, so a zero-size word never counts as allocated

	int gap_left = 0;
	int burst_left = 0;

	task automatic send_op(op_t op, int unsigned sz, int unsigned off);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
		end
		if (gap_left > 0) begin
			req.valid <= 0;
			while (gap_left > 0) begin
				@(posedge clk);
				gap_left--;
			end
		end
		burst_left--;
		req.valid <= 1;
		req.operation <= op;
		req.request_size <= sz[14:0];
		req.data_offset <= off[13:0];
		do @(posedge clk); while (!req.ready);
		if (op == OP_ALLOC) board.note_request(predict_alloc(sz));
		else board.note_request(predict_free(off));
	endtask

	task automatic drain();
		int n;
		n = 0;
		req.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		while (n < 2100) begin
			@(posedge clk);
			n++;
		end
	endtask

	task automatic write_heap(int unsigned v);
		drain();
		cfg.valid <= 1;
		cfg.size_bytes <= v[14:0];
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
		heap_init(v);
	endtask

	task automatic random_phase(int count);
		int unsigned k, sz, off;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 99);
			if (k < 50) begin
				case ($urandom_range(0, 9))
					0: sz = $urandom_range(0, 32767);
					1: sz = $urandom_range(1000, 16384);
					default: sz = $urandom_range(1, 300);
				endcase
				send_op(OP_ALLOC, sz, $urandom_range(0, 16383));
			end else if (k < 85 && live.size() != 0) begin
				off = live[$urandom_range(0, live.size() - 1)];
				send_op(OP_FREE, $urandom_range(0, 32767), off);
			end else if (k < 92) begin
				off = $urandom_range(0, 16383);
				send_op(OP_FREE, $urandom_range(0, 32767), off);
			end else begin
				off = $urandom_range(0, heap_bytes / 4) * 4;
				send_op(OP_FREE, 0, off);
			end
		end
	endtask

	// receiver stalls in runs
	int stall_run = 0;
	always @(posedge clk) begin
		if (stall_run > 0) begin
			stall_run <= stall_run - 1;
			rsp.ready <= 0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_run <= $urandom_range(1, 20);
			rsp.ready <= 0;
		end else rsp.ready <= 1;
		if (arst_n && rsp.valid && rsp.ready)
			board.check_reply({status_t'(rsp.status), rsp.result_offset, rsp.free_chunks});
	end

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int unsigned a;
		board = new();
		req.valid = 0;
		req.operation = OP_ALLOC;
		req.request_size = 0;
		req.data_offset = 0;
		cfg.valid = 0;
		cfg.size_bytes = 0;
		rsp.ready = 0;
		heap_init(MIN_HEAP_BYTES);
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed
		send_op(OP_ALLOC, 0, 0);
		send_op(OP_ALLOC, 32767, 16383);
		send_op(OP_ALLOC, 1, 0);
		a = 8;
		send_op(OP_ALLOC, 5, 0);
		send_op(OP_ALLOC, 4075, 0);
		send_op(OP_FREE, 0, 0);
		send_op(OP_FREE, 0, 4);
		send_op(OP_FREE, 0, 16383);
		send_op(OP_FREE, 0, 12);
		send_op(OP_FREE, 32767, a);
		send_op(OP_FREE, 0, a);
		send_op(OP_ALLOC, 16384, 0);
		send_op(OP_ALLOC, 4088, 0);
		send_op(OP_FREE, 0, 8);
		send_op(OP_ALLOC, 4060, 0);
		write_heap(0);
		send_op(OP_ALLOC, 4088, 0);
		write_heap(32767);
		send_op(OP_ALLOC, 16376, 0);
		send_op(OP_FREE, 0, 8);
		send_op(OP_ALLOC, 16377, 0);
		random_phase(150);
		write_heap(16384);
		random_phase(150);
		write_heap(6001);
		random_phase(140);
		write_heap(4096);
		random_phase(140);
		drain();
		if (board.fails == 0 && board.pending.size() == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
